[rtl/core/ct8_pkg.sv]
package ct8_pkg;

	localparam int unsigned COORD_W = 8;
	localparam int unsigned ADDR_W  = 2 * COORD_W;
	localparam int unsigned REG_W   = 9;
	localparam int unsigned STEP_W  = 17;
	localparam logic [REG_W-1:0] MAX_DIM = 9'd256;

	localparam logic [2:0] STAT_POINT  = 3'd0;
	localparam logic [2:0] STAT_CLOSED = 3'd1;
	localparam logic [2:0] STAT_OPEN   = 3'd2;
	localparam logic [2:0] STAT_NONE   = 3'd3;
	localparam logic [2:0] STAT_CAP    = 3'd4;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] alpha;
	} ct8_in_t;

	typedef struct packed {
		logic [7:0] point_x;
		logic [7:0] point_y;
		logic [2:0] status;
		logic       last;
	} ct8_out_t;

	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} ct8_nb_t;

	// Direction order: N, NW, W, SW, S, SE, E, NE (y grows downwards)
	function automatic logic [1:0] dir_dx(input logic [2:0] d);
		logic [1:0] r;
		case (d)
			3'd0, 3'd4: r = 2'b00;
			3'd1, 3'd2, 3'd3: r = 2'b11;
			default: r = 2'b01;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] dir_dy(input logic [2:0] d);
		logic [1:0] r;
		case (d)
			3'd0, 3'd1, 3'd7: r = 2'b11;
			3'd2, 3'd6: r = 2'b00;
			default: r = 2'b01;
		endcase
		return r;
	endfunction

	function automatic ct8_nb_t neighbour(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [2:0] d,
			input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
		logic [1:0]         ddx;
		logic [1:0]         ddy;
		logic [COORD_W+1:0] nx;
		logic [COORD_W+1:0] ny;
		ct8_nb_t r;
		ddx = dir_dx(d);
		ddy = dir_dy(d);
		nx = {2'b00, x} + {{COORD_W{ddx[1]}}, ddx};
		ny = {2'b00, y} + {{COORD_W{ddy[1]}}, ddy};
		r.ok = !nx[COORD_W+1] && (nx[COORD_W:0] < w)
			&& !ny[COORD_W+1] && (ny[COORD_W:0] < h);
		r.x = nx[COORD_W-1:0];
		r.y = ny[COORD_W-1:0];
		return r;
	endfunction

	function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] v);
		logic [REG_W-1:0] r;
		if (v == '0) begin
			r = 9'd1;
		end else if (v > MAX_DIM) begin
			r = MAX_DIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[rtl/core/ct8_map.sv]
module ct8_map (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ct8_pkg::ADDR_W-1:0] waddr,
	input  logic                       wbit,
	input  logic [ct8_pkg::ADDR_W-1:0] raddr,
	output logic                       rbit
);
	import ct8_pkg::*;

	// one bit per pixel, row-major with a fixed row pitch
	logic mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wbit;
		end
		rbit <= mem[raddr];
	end

endmodule

[rtl/core/contour_tracer_8_connected.sv]
// Loads: a beat is taken whenever the tracer is idle; no result.
// Trace start: a full scan over every pixel of the image.
// Trace step: up to 8 neighbour probes, paced by the single read port of the
// border map; the result then goes out through ST_EMIT.
// arst_n clears control state, sets both dimensions to 256; maps are not cleared.
module contour_tracer_8_connected (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ct8_pkg::ct8_in_t            req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ct8_pkg::ct8_out_t           res,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [ct8_pkg::REG_W-1:0]   cfg_data
);
	import ct8_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SC_C  = 9'b000000010, // read centre opacity
		ST_SC_CW = 9'b000000100,
		ST_SC_N  = 9'b000001000, // read neighbour opacity
		ST_SC_NW = 9'b000010000,
		ST_SC_W  = 9'b000100000, // write border bit, advance
		ST_TR_P  = 9'b001000000, // probe border neighbour
		ST_TR_W  = 9'b010000000,
		ST_EMIT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [REG_W-1:0]   width_q, height_q;
	logic [REG_W-1:0]   w_eff, h_eff;
	logic [STEP_W-1:0]  area_q;    // w*h, registered
	logic [STEP_W:0]    step_cap;
	logic [COORD_W-1:0] lx_q, ly_q;
	logic [COORD_W-1:0] sx_q, sy_q;
	logic [2:0]         sd_q;
	logic               sb_q, found_q;
	logic [COORD_W-1:0] cx_q, cy_q, stx_q, sty_q;
	logic [2:0]         prev_q, ti_q;
	logic               tracing_q;
	logic [STEP_W-1:0]  step_q;
	ct8_out_t           pend_q;
	ct8_out_t           res_q;
	logic               res_valid_q;

	logic [2:0]         tdir;
	ct8_nb_t            snb, tnb;
	logic               opq_we, opq_rd, brd_rd;
	logic [ADDR_W-1:0]  opq_raddr;
	logic               req_acc;
	logic               sx_end, sy_end, lx_end, ly_end;

	assign w_eff    = eff_dim(width_q);
	assign h_eff    = eff_dim(height_q);
	assign step_cap = {area_q, 1'b0} - {{STEP_W{1'b0}}, 1'b1};

	assign tdir = prev_q + 3'd5 + ti_q;
	assign snb  = neighbour(sx_q, sy_q, sd_q, w_eff, h_eff);
	assign tnb  = neighbour(cx_q, cy_q, tdir, w_eff, h_eff);

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign opq_we    = req_acc && !req.func;
	assign opq_raddr = (state_q == ST_SC_C) ? {sy_q, sx_q} : {snb.y, snb.x};

	assign sx_end = ({1'b0, sx_q} == w_eff - 9'd1);
	assign sy_end = ({1'b0, sy_q} == h_eff - 9'd1);
	assign lx_end = ({1'b0, lx_q} == w_eff - 9'd1);
	assign ly_end = ({1'b0, ly_q} == h_eff - 9'd1);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	ct8_map u_opaque (
		.clk   (clk),
		.we    (opq_we),
		.waddr ({ly_q, lx_q}),
		.wbit  (req.alpha != 8'd0),
		.raddr (opq_raddr),
		.rbit  (opq_rd)
	);

	ct8_map u_border (
		.clk   (clk),
		.we    (state_q == ST_SC_W),
		.waddr ({sy_q, sx_q}),
		.wbit  (sb_q),
		.raddr ({tnb.y, tnb.x}),
		.rbit  (brd_rd)
	);

	// area product for the step cap; dimensions are to change only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= 17'h10000;
		end else begin
			area_q <= STEP_W'({8'd0, w_eff} * {8'd0, h_eff});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= MAX_DIM;
			height_q    <= MAX_DIM;
			lx_q        <= '0;
			ly_q        <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			sd_q        <= '0;
			sb_q        <= 1'b0;
			found_q     <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			stx_q       <= '0;
			sty_q       <= '0;
			prev_q      <= '0;
			ti_q        <= '0;
			tracing_q   <= 1'b0;
			step_q      <= '0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
				lx_q      <= '0;
				ly_q      <= '0;
				tracing_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && !req.func) begin
						// raster load, wrap after the last pixel
						tracing_q <= 1'b0;
						if (lx_end) begin
							lx_q <= '0;
							ly_q <= ly_end ? '0 : ly_q + 8'd1;
						end else begin
							lx_q <= lx_q + 8'd1;
						end
					end else if (req_acc && !tracing_q) begin
						sx_q    <= '0;
						sy_q    <= '0;
						found_q <= 1'b0;
						state_q <= ST_SC_C;
					end else if (req_acc) begin
						if ({1'b0, step_q} >= step_cap) begin
							tracing_q <= 1'b0;
							pend_q    <= '{cx_q, cy_q, STAT_CAP, 1'b1};
							state_q   <= ST_EMIT;
						end else begin
							ti_q    <= '0;
							state_q <= ST_TR_P;
						end
					end
				end
				ST_SC_C: state_q <= ST_SC_CW;
				ST_SC_CW: begin
					sd_q <= '0;
					sb_q <= 1'b0;
					state_q <= opq_rd ? ST_SC_N : ST_SC_W;
				end
				ST_SC_N: begin
					if (!snb.ok) begin
						sb_q    <= 1'b1;
						state_q <= ST_SC_W;
					end else begin
						state_q <= ST_SC_NW;
					end
				end
				ST_SC_NW: begin
					if (!opq_rd) begin
						sb_q    <= 1'b1;
						state_q <= ST_SC_W;
					end else if (sd_q == 3'd7) begin
						state_q <= ST_SC_W;
					end else begin
						sd_q    <= sd_q + 3'd1;
						state_q <= ST_SC_N;
					end
				end
				ST_SC_W: begin
					if (sb_q && !found_q) begin
						found_q <= 1'b1;
						stx_q   <= sx_q;
						sty_q   <= sy_q;
					end
					if (sx_end && sy_end) begin
						step_q  <= '0;
						state_q <= ST_EMIT;
						if (found_q) begin
							cx_q      <= stx_q;
							cy_q      <= sty_q;
							prev_q    <= 3'd3;
							tracing_q <= 1'b1;
							pend_q    <= '{stx_q, sty_q, STAT_POINT, 1'b0};
						end else if (sb_q) begin
							cx_q      <= sx_q;
							cy_q      <= sy_q;
							prev_q    <= 3'd3;
							tracing_q <= 1'b1;
							pend_q    <= '{sx_q, sy_q, STAT_POINT, 1'b0};
						end else begin
							tracing_q <= 1'b0;
							pend_q    <= '{8'd0, 8'd0, STAT_NONE, 1'b1};
						end
					end else begin
						if (sx_end) begin
							sx_q <= '0;
							sy_q <= sy_q + 8'd1;
						end else begin
							sx_q <= sx_q + 8'd1;
						end
						state_q <= ST_SC_C;
					end
				end
				ST_TR_P: begin
					if (tnb.ok) begin
						state_q <= ST_TR_W;
					end else if (ti_q == 3'd7) begin
						tracing_q <= 1'b0;
						pend_q    <= '{cx_q, cy_q, STAT_OPEN, 1'b1};
						state_q   <= ST_EMIT;
					end else begin
						ti_q <= ti_q + 3'd1;
					end
				end
				ST_TR_W: begin
					if (brd_rd) begin
						cx_q    <= tnb.x;
						cy_q    <= tnb.y;
						prev_q  <= tdir;
						step_q  <= step_q + 17'd1;
						state_q <= ST_EMIT;
						if (tnb.x == stx_q && tnb.y == sty_q) begin
							tracing_q <= 1'b0;
							pend_q    <= '{tnb.x, tnb.y, STAT_CLOSED, 1'b1};
						end else begin
							pend_q    <= '{tnb.x, tnb.y, STAT_POINT, 1'b0};
						end
					end else if (ti_q == 3'd7) begin
						tracing_q <= 1'b0;
						pend_q    <= '{cx_q, cy_q, STAT_OPEN, 1'b1};
						state_q   <= ST_EMIT;
					end else begin
						ti_q    <= ti_q + 3'd1;
						state_q <= ST_TR_P;
					end
				end
				ST_EMIT: begin
					// hold until the output register frees up
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!res_valid_q || res_ready)) begin
			res_q <= pend_q;
		end
	end

`ifndef ASSERT_OFF
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.func && !tracing_q) |=> state_q == ST_SC_C)
		else $error("trace request did not start a scan");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tracing_q |-> {1'b0, step_q} <= step_cap)
		else $error("step count beyond cap");

	a_none_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == STAT_NONE) |-> (res.point_x == 8'd0
			&& res.point_y == 8'd0 && res.last))
		else $error("no-border beat carries a point");

	a_probe_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TR_W |-> $past(state_q == ST_TR_P))
		else $error("border data checked without a read");
`endif

endmodule
